// ===== hdl/dmx512_frame_receiver_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the DMX512 frame receiver
// Shared property wrappers with a common clock, reset and error report.
// ---------------------------------------------------------------------------
`ifndef DMX512_FRAME_RECEIVER_CORE_MACROS_SVH
`define DMX512_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define DMXR_ASSERT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dmxr assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define DMXR_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dmxr assertion failed");

`endif

// ===== hdl/dmxr_pkg.sv =====
// ---------------------------------------------------------------------------
// DMX512 receiver package
// Widths, event codes, register indexes and the structs shared by the block.
// ---------------------------------------------------------------------------
package dmxr_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_W   = 10;

  // Slot counter saturation value.
  localparam logic [SLOT_W-1:0] SLOT_SAT = {SLOT_W{1'b1}};

  // Event queue between the front and the back; a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Receive event codes on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_BYTE     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BREAK    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_OVERFLOW = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FRAMING  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DESYNC   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_START_ADDRESS = 1'b0;
  localparam logic CFG_WINDOW_SIZE   = 1'b1;

  typedef enum logic [2:0] {
    CMD_BYTE,
    CMD_BREAK,
    CMD_OVERFLOW,
    CMD_FRAMING,
    CMD_DESYNC,
    CMD_ABORT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [BYTE_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic                write_enable;
    logic [INDEX_W-1:0]  write_index;
    logic [BYTE_W-1:0]   write_value;
    logic                frame_done;
    logic [SLOT_W-1:0]   frame_length;
    logic [CNT_W-1:0]    break_count;
    logic [CNT_W-1:0]    overflow_count;
    logic [CNT_W-1:0]    error_count;
    logic [CNT_W-1:0]    desync_count;
    logic [CNT_W-1:0]    dimmer_count;
    logic [CNT_W-1:0]    unknown_count;
  } res_t;

endpackage

// ===== hdl/dmxr_if.sv =====
// ---------------------------------------------------------------------------
// DMX512 receiver channel interfaces
// Valid/ready channels for receive events and for results.
// ---------------------------------------------------------------------------
interface dmxr_evt_if;
  logic                           valid;
  logic                           ready;
  logic [dmxr_pkg::FUNC_W-1:0]    func;
  logic [dmxr_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface dmxr_res_if;
  logic                           valid;
  logic                           ready;
  logic                           write_enable;
  logic [dmxr_pkg::INDEX_W-1:0]   write_index;
  logic [dmxr_pkg::BYTE_W-1:0]    write_value;
  logic                           frame_done;
  logic [dmxr_pkg::SLOT_W-1:0]    frame_length;
  logic [dmxr_pkg::CNT_W-1:0]     break_count;
  logic [dmxr_pkg::CNT_W-1:0]     overflow_count;
  logic [dmxr_pkg::CNT_W-1:0]     error_count;
  logic [dmxr_pkg::CNT_W-1:0]     desync_count;
  logic [dmxr_pkg::CNT_W-1:0]     dimmer_count;
  logic [dmxr_pkg::CNT_W-1:0]     unknown_count;

  modport source (
    output valid, output write_enable, output write_index, output write_value,
    output frame_done, output frame_length, output break_count,
    output overflow_count, output error_count, output desync_count,
    output dimmer_count, output unknown_count, input ready
  );
  modport sink (
    input valid, input write_enable, input write_index, input write_value,
    input frame_done, input frame_length, input break_count,
    input overflow_count, input error_count, input desync_count,
    input dimmer_count, input unknown_count, output ready
  );
endinterface

// ===== hdl/dmxr_front.sv =====
// ---------------------------------------------------------------------------
// DMX512 receiver front end
// Accepts receive events and classifies them into queue commands.
// ---------------------------------------------------------------------------
module dmxr_front (
  input  logic                        evt_valid_i,
  input  logic [dmxr_pkg::FUNC_W-1:0] evt_func_i,
  input  logic [dmxr_pkg::BYTE_W-1:0] evt_data_i,
  output logic                        evt_ready_o,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output dmxr_pkg::cmd_t              cmd_o
);

  assign evt_ready_o = !queue_full_i;
  assign push_o      = evt_valid_i && !queue_full_i;

  // Unused event codes behave like an abort.
  always_comb begin
    cmd_o.data = evt_data_i;
    unique case (evt_func_i)
      dmxr_pkg::FUNC_BYTE:     cmd_o.kind = dmxr_pkg::CMD_BYTE;
      dmxr_pkg::FUNC_BREAK:    cmd_o.kind = dmxr_pkg::CMD_BREAK;
      dmxr_pkg::FUNC_OVERFLOW: cmd_o.kind = dmxr_pkg::CMD_OVERFLOW;
      dmxr_pkg::FUNC_FRAMING:  cmd_o.kind = dmxr_pkg::CMD_FRAMING;
      dmxr_pkg::FUNC_DESYNC:   cmd_o.kind = dmxr_pkg::CMD_DESYNC;
      default:                 cmd_o.kind = dmxr_pkg::CMD_ABORT;
    endcase
  end

endmodule

// ===== hdl/dmxr_queue.sv =====
// ---------------------------------------------------------------------------
// DMX512 receiver command queue
// Small first-in first-out buffer between the front and the back end.
// ---------------------------------------------------------------------------
module dmxr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dmxr_pkg::cmd_t       cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output dmxr_pkg::cmd_t       cmd_o
);

  dmxr_pkg::cmd_t                       mem_q [dmxr_pkg::QUEUE_DEPTH];
  logic [dmxr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
  logic [dmxr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
  logic [dmxr_pkg::QUEUE_CNT_W-1:0]     count_q;
  logic [dmxr_pkg::QUEUE_CNT_W-1:0]     count_d;

  localparam logic [dmxr_pkg::QUEUE_CNT_W-1:0] Depth =
    dmxr_pkg::QUEUE_CNT_W'(dmxr_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == Depth);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      // Pointers wrap naturally since the depth is a power of two.
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/dmxr_exec.sv =====
// ---------------------------------------------------------------------------
// DMX512 receiver back end
// Runs the frame state machine, keeps the counters and registers results.
// ---------------------------------------------------------------------------
module dmxr_exec #(
  parameter int unsigned MaxSlots = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [dmxr_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        cmd_valid_i,
  input  dmxr_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output dmxr_pkg::res_t              res_o
);

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  localparam logic [dmxr_pkg::SLOT_W-1:0] MaxSlotsW = dmxr_pkg::SLOT_W'(MaxSlots);
  localparam logic [dmxr_pkg::SLOT_W-1:0] WindowReset =
    dmxr_pkg::SLOT_W'(512);

  logic [dmxr_pkg::CFG_W-1:0]  start_q, window_q;
  logic [1:0]                  phase_q, phase_d;
  logic [dmxr_pkg::SLOT_W-1:0] slot_cnt_q, slot_cnt_d;
  logic [dmxr_pkg::SLOT_W-1:0] stored_q, stored_d;
  logic [dmxr_pkg::CNT_W-1:0]  breaks_q, breaks_d;
  logic [dmxr_pkg::CNT_W-1:0]  ovf_q, ovf_d;
  logic [dmxr_pkg::CNT_W-1:0]  err_q, err_d;
  logic [dmxr_pkg::CNT_W-1:0]  desync_q, desync_d;
  logic [dmxr_pkg::CNT_W-1:0]  dimmer_q, dimmer_d;
  logic [dmxr_pkg::CNT_W-1:0]  other_q, other_d;
  logic                        res_valid_q;
  dmxr_pkg::res_t              res_q, res_d;

  logic [dmxr_pkg::SLOT_W-1:0] slot, rel, limit;
  logic                        in_win;

  // Take a command whenever the result register is free or being drained.
  assign pop_o       = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Window position of the next data slot.
  always_comb begin
    limit = (window_q > MaxSlotsW) ? MaxSlotsW : window_q;
    slot  = slot_cnt_q + 1'b1;
    if (start_q == '0) begin
      in_win = 1'b1;
      rel    = slot_cnt_q;
    end else begin
      in_win = (slot >= start_q);
      rel    = slot - start_q;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    slot_cnt_d = slot_cnt_q;
    stored_d   = stored_q;
    breaks_d   = breaks_q;
    ovf_d      = ovf_q;
    err_d      = err_q;
    desync_d   = desync_q;
    dimmer_d   = dimmer_q;
    other_d    = other_q;
    res_d      = '0;

    unique case (cmd_i.kind)
      dmxr_pkg::CMD_BYTE: begin
        unique case (phase_q)
          PH_START: begin
            stored_d = '0;
            if (cmd_i.data == '0) begin
              dimmer_d   = dimmer_q + 1'b1;
              phase_d    = PH_DATA;
              slot_cnt_d = '0;
            end else begin
              other_d = other_q + 1'b1;
              phase_d = PH_SKIP;
            end
          end
          PH_DATA: begin
            if (slot_cnt_q != dmxr_pkg::SLOT_SAT) begin
              slot_cnt_d = slot;
              if (in_win && (rel < limit)) begin
                res_d.write_enable = 1'b1;
                res_d.write_index  = rel[dmxr_pkg::INDEX_W-1:0];
                res_d.write_value  = cmd_i.data;
                stored_d           = stored_q + 1'b1;
              end
            end
          end
          PH_WAIT, PH_SKIP: begin
          end
          default: begin
          end
        endcase
      end
      dmxr_pkg::CMD_BREAK: begin
        // The stored count survives the break, so a repeated break reports again.
        breaks_d = breaks_q + 1'b1;
        if (stored_q != '0) begin
          res_d.frame_done   = 1'b1;
          res_d.frame_length = stored_q;
        end
        phase_d = PH_START;
      end
      dmxr_pkg::CMD_OVERFLOW: begin
        ovf_d    = ovf_q + 1'b1;
        phase_d  = PH_WAIT;
        stored_d = '0;
      end
      dmxr_pkg::CMD_FRAMING: begin
        err_d    = err_q + 1'b1;
        phase_d  = PH_WAIT;
        stored_d = '0;
      end
      dmxr_pkg::CMD_DESYNC: begin
        desync_d = desync_q + 1'b1;
        phase_d  = PH_WAIT;
        stored_d = '0;
      end
      default: begin
        phase_d  = PH_WAIT;
        stored_d = '0;
      end
    endcase

    res_d.break_count    = breaks_d;
    res_d.overflow_count = ovf_d;
    res_d.error_count    = err_d;
    res_d.desync_count   = desync_d;
    res_d.dimmer_count   = dimmer_d;
    res_d.unknown_count  = other_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      window_q    <= WindowReset;
      phase_q     <= PH_WAIT;
      slot_cnt_q  <= '0;
      stored_q    <= '0;
      breaks_q    <= '0;
      ovf_q       <= '0;
      err_q       <= '0;
      desync_q    <= '0;
      dimmer_q    <= '0;
      other_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dmxr_pkg::CFG_START_ADDRESS: start_q  <= cfg_data_i;
          dmxr_pkg::CFG_WINDOW_SIZE:   window_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (pop_o) begin
        phase_q    <= phase_d;
        slot_cnt_q <= slot_cnt_d;
        stored_q   <= stored_d;
        breaks_q   <= breaks_d;
        ovf_q      <= ovf_d;
        err_q      <= err_d;
        desync_q   <= desync_d;
        dimmer_q   <= dimmer_d;
        other_q    <= other_d;
      end
      if (pop_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== hdl/dmx512_frame_receiver_core.sv =====
// ---------------------------------------------------------------------------
// DMX512 frame receiver core
// Turns a stream of receive events into slot writes, frame reports and
// running statistics counters.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                 Handshake
//   evt_i     in         func, data_byte                         valid/ready
//   res_o     out        slot write, frame report, six counters  valid/ready
//   cfg       in         cfg_index_i, cfg_data_i                 cfg_we_i only
//
// One event is taken per clock cycle when nothing stalls, and each event
// yields exactly one result transaction through the command queue and then
// the result register. The rate is set by the back end, which handles one
// command per cycle while the result register is free or being drained.
// Reset clears the state machine, counters and queue; the block is ready
// once reset is released. A stalled result register lets up to three
// events pile up (two queued plus one held) before evt_i.ready drops.
//
module dmx512_frame_receiver_core #(
  parameter int unsigned MaxSlots = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [dmxr_pkg::CFG_W-1:0]  cfg_data_i,
  dmxr_evt_if.sink                    evt_i,
  dmxr_res_if.source                  res_o
);

  dmxr_pkg::cmd_t      front_cmd;
  dmxr_pkg::cmd_t      queue_cmd;
  logic                queue_push;
  logic                queue_full;
  logic                queue_valid;
  logic                queue_pop;
  dmxr_pkg::res_t      res;

  // The front end classifies each event code and pushes it into the queue.
  dmxr_front u_front (
    .evt_valid_i  (evt_i.valid),
    .evt_func_i   (evt_i.func),
    .evt_data_i   (evt_i.data_byte),
    .evt_ready_o  (evt_i.ready),
    .queue_full_i (queue_full),
    .push_o       (queue_push),
    .cmd_o        (front_cmd)
  );

  // The queue lets the front keep accepting while the result side stalls.
  dmxr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // The back end owns the configuration registers and all frame state.
  dmxr_exec #(
    .MaxSlots (MaxSlots)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (queue_pop),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  // The result register drives the output channel directly.
  assign res_o.write_enable   = res.write_enable;
  assign res_o.write_index    = res.write_index;
  assign res_o.write_value    = res.write_value;
  assign res_o.frame_done     = res.frame_done;
  assign res_o.frame_length   = res.frame_length;
  assign res_o.break_count    = res.break_count;
  assign res_o.overflow_count = res.overflow_count;
  assign res_o.error_count    = res.error_count;
  assign res_o.desync_count   = res.desync_count;
  assign res_o.dimmer_count   = res.dimmer_count;
  assign res_o.unknown_count  = res.unknown_count;

endmodule

// ===== hdl/dmxr_checker.sv =====
// ---------------------------------------------------------------------------
// DMX512 receiver port checker
// Watches the top-level ports for ordering and occupancy slips.
// ---------------------------------------------------------------------------
`include "dmx512_frame_receiver_core_macros.svh"

module dmxr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        write_enable_i,
  input logic [dmxr_pkg::INDEX_W-1:0] write_index_i,
  input logic                        frame_done_i,
  input logic [dmxr_pkg::SLOT_W-1:0] frame_length_i,
  input logic [dmxr_pkg::CNT_W-1:0]  break_count_i
);

  logic       in_fire;
  logic       out_fire;
  logic [2:0] pending_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Events taken but not yet delivered as results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_fire && !out_fire) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `DMXR_ASSERT(a_no_result_without_event, clk_i, rst_ni, out_valid_i, pending_q != 3'd0)

  `DMXR_ASSERT(a_pending_bounded, clk_i, rst_ni, 1'b1, pending_q <= 3'd3)

  `DMXR_ASSERT(a_done_has_length, clk_i, rst_ni, out_valid_i && frame_done_i, (frame_length_i != '0) && !write_enable_i)

  `DMXR_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(write_index_i) && $stable(break_count_i) && $stable(frame_done_i))

endmodule

bind dmx512_frame_receiver_core dmxr_checker u_dmxr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (evt_i.valid),
  .in_ready_i     (evt_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .write_enable_i (res_o.write_enable),
  .write_index_i  (res_o.write_index),
  .frame_done_i   (res_o.frame_done),
  .frame_length_i (res_o.frame_length),
  .break_count_i  (res_o.break_count)
);
